@@ hdl/skt_pkg.sv @@
// Shared types, codes and defaults for the sorted key table.
package skt_pkg;

   // default number of cells in the chain
   localparam int DEPTH_DEFAULT = 16;

   // request action codes
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_LIST   = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   // cell operation codes
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_DELETE = 2'd2;
   localparam logic [1:0] CELL_ROTATE = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] record_key;
      logic [7:0]         record_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] out_key;
      logic [7:0]         out_tag;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic [7:0]         tag;
   } record_type;

   // command broadcast to every cell
   typedef struct packed {
      logic [1:0] op;
      record_type rec;
   } cell_ctl_type;

endpackage

@@ hdl/sorted_key_table_top.sv @@
// Top level of the sorted key table: cell chain plus request and response control.
//
// Keeps up to DEPTH records (signed key, tag) in ascending key order in a chain of
// cells, each holding one record. On an insert or delete every cell compares
// its key with the request key in parallel and shifts toward or away from its
// neighbor, so one item is accepted per cycle while no list is in progress and
// the response register is free; each insert or delete gets one response, an
// unused action code none. An insert goes ahead of equal keys; a delete removes
// the first matching record. A list request gets one response per stored record,
// or a single empty response if the table is empty. Once a list is accepted the
// chain rotates by one cell per response and the head cell is sent out; after the
// last record the chain is back in its original order. A response waits in an
// output register; a new item is taken whenever it is empty or being drained.
module sorted_key_table_top
   import skt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   localparam int CW = $clog2(DEPTH + 1);

   cell_ctl_type ctl;
   record_type   cell_rec   [DEPTH];
   logic         cell_valid [DEPTH];
   logic         cell_ge    [DEPTH];
   logic         cell_hit   [DEPTH];

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] step_ff, step_in;
   logic          list_ff, list_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_item_ff, rsp_item_in;

   logic rsp_free;
   logic accept;
   logic full;
   logic found;
   logic last_step;

   // build the chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic       prev_ge_w;
      record_type left_rec_w;
      logic       left_valid_w;
      record_type right_rec_w;
      logic       right_valid_w;
      logic       hit_in_w;

      if (i == 0) begin : g_head
         assign prev_ge_w    = 1'b0;
         assign left_rec_w   = ctl.rec;
         assign left_valid_w = 1'b1;
         assign hit_in_w     = 1'b0;
      end else begin : g_body
         assign prev_ge_w    = cell_ge[i-1];
         assign left_rec_w   = cell_rec[i-1];
         assign left_valid_w = cell_valid[i-1];
         assign hit_in_w     = cell_hit[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_rec_w   = cell_rec[i];
         assign right_valid_w = 1'b0;
      end else begin : g_inner
         assign right_rec_w   = cell_rec[i+1];
         assign right_valid_w = cell_valid[i+1];
      end

      skt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .prev_ge     (prev_ge_w),
         .left_rec    (left_rec_w),
         .left_valid  (left_valid_w),
         .right_rec   (right_rec_w),
         .right_valid (right_valid_w),
         .wrap_rec    (cell_rec[0]),
         .hit_in      (hit_in_w),
         .rec         (cell_rec[i]),
         .valid       (cell_valid[i]),
         .ge          (cell_ge[i]),
         .hit_out     (cell_hit[i])
      );
   end

   // handshake on both sides
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = list_ff || !rsp_free;
   assign accept    = req_valid && !req_stall;

   assign full      = (count_ff == CW'(DEPTH));
   assign found     = cell_hit[DEPTH-1];
   assign last_step = (CW'(step_ff + 1'b1) == count_ff);

   // decode the accepted item or the next list step
   always_comb begin
      ctl.op       = CELL_HOLD;
      ctl.rec.key  = req_item.record_key;
      ctl.rec.tag  = req_item.record_tag;
      count_in     = count_ff;
      step_in      = step_ff;
      list_in      = list_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;

      if (list_ff) begin
         if (rsp_free) begin
            ctl.op               = CELL_ROTATE;
            rsp_valid_in         = 1'b1;
            rsp_item_in.status   = ST_OK;
            rsp_item_in.out_key  = cell_rec[0].key;
            rsp_item_in.out_tag  = cell_rec[0].tag;
            rsp_item_in.last     = last_step;
            step_in              = CW'(step_ff + 1'b1);
            if (last_step) begin
               list_in = 1'b0;
            end
         end
      end else if (accept) begin
         rsp_item_in.out_key = '0;
         rsp_item_in.out_tag = '0;
         rsp_item_in.last    = 1'b1;
         case (req_item.action)
            ACT_INSERT: begin
               rsp_valid_in = 1'b1;
               if (full) begin
                  rsp_item_in.status = ST_FULL;
               end else begin
                  ctl.op             = CELL_INSERT;
                  count_in           = CW'(count_ff + 1'b1);
                  rsp_item_in.status = ST_OK;
               end
            end
            ACT_DELETE: begin
               rsp_valid_in = 1'b1;
               if (found) begin
                  ctl.op             = CELL_DELETE;
                  count_in           = CW'(count_ff - 1'b1);
                  rsp_item_in.status = ST_OK;
               end else begin
                  rsp_item_in.status = ST_NOT_FOUND;
               end
            end
            ACT_LIST: begin
               if (count_ff == '0) begin
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.status = ST_EMPTY;
               end else begin
                  list_in = 1'b1;
                  step_in = '0;
               end
            end
            default: begin
               // drop unused action codes silently
            end
         endcase
      end
   end

   // advance control and response registers
   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      step_ff     <= step_in;
      if (reset) begin
         count_ff     <= '0;
         list_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         list_ff      <= list_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

@@ hdl/skt_cell.sv @@
// One cell of the sorted chain: holds a single record and its valid bit.
module skt_cell
   import skt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic         prev_ge,
   input  record_type   left_rec,
   input  logic         left_valid,
   input  record_type   right_rec,
   input  logic         right_valid,
   input  record_type   wrap_rec,
   input  logic         hit_in,
   output record_type   rec,
   output logic         valid,
   output logic         ge,
   output logic         hit_out
);

   record_type rec_ff, rec_in;
   logic       valid_ff, valid_in;
   logic       eq;

   // compare the stored key against the broadcast key
   assign ge      = !valid_ff || !(rec_ff.key < ctl.rec.key);
   assign eq      = valid_ff && (rec_ff.key == ctl.rec.key);
   assign hit_out = hit_in || eq;

   // pick the next contents of this cell
   always_comb begin
      rec_in   = rec_ff;
      valid_in = valid_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (prev_ge) begin
               rec_in   = left_rec;
               valid_in = left_valid;
            end else if (ge) begin
               rec_in   = ctl.rec;
               valid_in = 1'b1;
            end
         end
         CELL_DELETE: begin
            if (hit_out) begin
               rec_in   = right_rec;
               valid_in = right_valid;
            end
         end
         CELL_ROTATE: begin
            if (valid_ff) begin
               rec_in = right_valid ? right_rec : wrap_rec;
            end
         end
         default: begin
         end
      endcase
   end

   // hold the record; only the valid bit needs a reset
   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rec   = rec_ff;
   assign valid = valid_ff;

endmodule

@@ test/tb_top.sv @@
// Testbench for the sorted key table: random and directed items checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
   import skt_pkg::*;

   // action code that the block ignores
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int TABLE_DEPTH = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 260;
   localparam int DRAIN_CYCLES = 40;

   // Track the ordered table and hold the responses it should produce.
   class key_table_scoreboard;
      logic signed [31:0] stored_keys[TABLE_DEPTH];
      logic [7:0]         stored_tags[TABLE_DEPTH];
      int                 entry_count;
      rsp_type            expected_rsps[$];
      int                 error_count;

      function new();
         entry_count = 0;
         error_count = 0;
      endfunction

      function void push_rsp(logic [1:0] status, logic signed [31:0] k, logic [7:0] t,
                             logic last);
         rsp_type r;
         r.status  = status;
         r.out_key = k;
         r.out_tag = t;
         r.last    = last;
         expected_rsps.push_back(r);
      endfunction

      // Apply an accepted item to the table and queue its responses.
      function void note_request(req_type req);
         int pos;
         case (req.action)
            ACT_INSERT: begin
               if (entry_count >= TABLE_DEPTH) begin
                  push_rsp(ST_FULL, '0, '0, 1'b1);
               end else begin
                  pos = 0;
                  while (pos < entry_count &&
                         $signed(stored_keys[pos]) < $signed(req.record_key))
                     pos++;
                  for (int i = entry_count; i > pos; i--) begin
                     stored_keys[i] = stored_keys[i-1];
                     stored_tags[i] = stored_tags[i-1];
                  end
                  stored_keys[pos] = req.record_key;
                  stored_tags[pos] = req.record_tag;
                  entry_count++;
                  push_rsp(ST_OK, '0, '0, 1'b1);
               end
            end
            ACT_DELETE: begin
               pos = 0;
               while (pos < entry_count && stored_keys[pos] != req.record_key)
                  pos++;
               if (pos >= entry_count) begin
                  push_rsp(ST_NOT_FOUND, '0, '0, 1'b1);
               end else begin
                  for (int i = pos; i + 1 < entry_count; i++) begin
                     stored_keys[i] = stored_keys[i+1];
                     stored_tags[i] = stored_tags[i+1];
                  end
                  entry_count--;
                  push_rsp(ST_OK, '0, '0, 1'b1);
               end
            end
            ACT_LIST: begin
               if (entry_count == 0) begin
                  push_rsp(ST_EMPTY, '0, '0, 1'b1);
               end else begin
                  for (int i = 0; i < entry_count; i++)
                     push_rsp(ST_OK, stored_keys[i], stored_tags[i],
                              (i == entry_count - 1));
               end
            end
            default: ;
         endcase
      endfunction

      // Compare a received response with the oldest expected one.
      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsps.size() == 0) begin
            $error("unexpected response: status %0d key %0d tag %0d last %0d",
                   got.status, $signed(got.out_key), got.out_tag, got.last);
            error_count++;
            return;
         end
         want = expected_rsps.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
         end
         if (got.out_key !== want.out_key) begin
            $error("out_key: expected %0d, got %0d", $signed(want.out_key),
                   $signed(got.out_key));
            error_count++;
         end
         if (got.out_tag !== want.out_tag) begin
            $error("out_tag: expected %0d, got %0d", want.out_tag, got.out_tag);
            error_count++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_item;

   key_table_scoreboard table_sb = new();

   // set while gaps are suppressed on both sides
   bit calm;
   // request for one long receiver hold-off
   bit long_hold;

   sorted_key_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Record accepted items and check accepted responses.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            table_sb.note_request(req_item);
         if (rsp_valid && !rsp_stall)
            table_sb.check_response(rsp_item);
      end
   end

   // Mostly no gap, some short ones, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(5, 25);
   endfunction

   // Keys mostly from a small pool so that duplicates and delete hits are common.
   function automatic logic signed [31:0] pick_key();
      logic signed [31:0] key_pool[8];
      key_pool = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 1, 100, -100, 12345};
      if ($urandom_range(0, 99) < 70)
         return key_pool[$urandom_range(0, 7)];
      return $urandom();
   endfunction

   // Offer one item, hold it until accepted, then idle for a random gap.
   task automatic send_item(input logic [1:0] act, input logic signed [31:0] k,
                            input logic [7:0] t);
      req_type item;
      int gap;
      item.action     = act;
      item.record_key = k;
      item.record_tag = t;
      req_item  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait for every expected response.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (table_sb.pending() != 0)
         @(posedge clock);
   endtask

   // Receiver: random stalls plus one long hold-off on request.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         if (long_hold) begin
            hold = 300;
            long_hold = 0;
         end else begin
            hold = pick_gap();
         end
         if (hold == 0) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Stimulus.
   initial begin
      int r;
      int insert_pct;
      int delete_pct;
      logic [1:0] act;
      logic signed [31:0] k;
      calm      = 0;
      long_hold = 0;
      req_valid = 1'b0;
      req_item  = '0;
      reset     = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty table, extremes, ordering before equal keys, first-match delete
      send_item(ACT_LIST, 0, 8'h00);
      send_item(ACT_DELETE, 0, 8'h00);
      send_item(ACT_INSERT, 32'sh7FFF_FFFF, 8'hFF);
      send_item(ACT_INSERT, 32'sh8000_0000, 8'h00);
      send_item(ACT_INSERT, 0, 8'h11);
      send_item(ACT_INSERT, 0, 8'h22);
      send_item(ACT_INSERT, -1, 8'h33);
      send_item(ACT_LIST, 0, 8'h00);
      send_item(ACT_DELETE, 0, 8'h00);
      send_item(ACT_DELETE, 7, 8'h00);
      send_item(ACT_UNUSED, -1, 8'hFF);
      send_item(ACT_DELETE, 32'sh8000_0000, 8'h00);
      send_item(ACT_DELETE, 32'sh7FFF_FFFF, 8'h00);
      send_item(ACT_LIST, 0, 8'h00);
      wait_drained();

      // fill the table, overflow it, list the full table
      while (table_sb.entry_count < TABLE_DEPTH)
         send_item(ACT_INSERT, pick_key(), 8'($urandom_range(0, 255)));
      send_item(ACT_INSERT, 55, 8'hA5);
      send_item(ACT_LIST, 0, 8'h00);
      wait_drained();

      // random part: alternate fill-heavy and drain-heavy stretches
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = ((n / 40) % 3 == 1);
         if (n == 60)
            long_hold = 1;
         if (n == 150)
            wait_drained();
         if ((n / 30) % 2 == 0) begin
            insert_pct = 70;
            delete_pct = 15;
         end else begin
            insert_pct = 20;
            delete_pct = 65;
         end
         r = $urandom_range(0, 99);
         if (r < insert_pct)
            act = ACT_INSERT;
         else if (r < insert_pct + delete_pct)
            act = ACT_DELETE;
         else if (r < 95)
            act = ACT_LIST;
         else
            act = ACT_UNUSED;
         k = pick_key();
         if (act == ACT_DELETE && table_sb.entry_count > 0 && $urandom_range(0, 99) < 60)
            k = table_sb.stored_keys[$urandom_range(0, table_sb.entry_count - 1)];
         send_item(act, k, 8'($urandom_range(0, 255)));
      end

      // let the last responses out, then report
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (table_sb.error_count == 0 && table_sb.pending() == 0)
         $display("PASS sorted_key_table_top");
      else
         $display("FAIL sorted_key_table_top");
      $finish;
   end

   // Watchdog.
   initial begin
      #5000000;
      $display("FAIL sorted_key_table_top");
      $finish;
   end

endmodule

@@ files.f @@
hdl/skt_pkg.sv
hdl/skt_cell.sv
hdl/sorted_key_table_top.sv
test/tb_top.sv
